@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define ASSERT_HOLDS(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check cons in the cycle after ante holds.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/eschcv_pkg.sv @@
// ----------------------------------------------------------------------------
// eschcv_pkg
// Types, constants and the decay table of the hysteresis cell voltage unit.
// ----------------------------------------------------------------------------
package eschcv_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_EFFICIENCY = 3'd0;
    localparam logic [2:0] CFG_RATE       = 3'd1;
    localparam logic [2:0] CFG_STEP_MS    = 3'd2;
    localparam logic [2:0] CFG_CAPACITY   = 3'd3;
    localparam logic [2:0] CFG_R0         = 3'd4;
    localparam logic [2:0] CFG_R1         = 3'd5;
    localparam logic [2:0] CFG_M0         = 3'd6;
    localparam logic [2:0] CFG_M          = 3'd7;

    // 3600 s/h * 1000 ms/s * 256 (Q8.8 rate scale)
    localparam logic [29:0] DEN_SCALE = 30'd921600000;

    localparam logic [30:0] EXP_ONE   = 31'h4000_0000;
    localparam logic [60:0] EXP_HALF  = 61'h2000_0000;

    // Divider step count: 20 fraction/integer bits of x plus an overflow bit.
    localparam int X_STEPS   = 21;
    localparam int EXP_TERMS = 20;

    // ceil(2^54 / 1000), split at bit 22; four partial products scale
    // nanovolts to microvolts exactly for magnitudes below 2^44.
    localparam logic [22:0] V_RECIP_HI = 23'd4294967;
    localparam logic [21:0] V_RECIP_LO = 22'd1241514;
    localparam int          V_TERMS    = 4;

    typedef struct packed {
        logic       capture;
        logic       mul0;
        logic       mul1;
        logic       mul2;
        logic       x_load;
        logic       div_step;
        logic       exp_step;
        logic [4:0] exp_idx;
        logic       h_calc;
        logic       v_mul;
        logic [1:0] v_idx;
        logic       v_calc;
        logic       out_load;
    } dp_cmd_t;

    // exp(-2^(k-16)) in Q30
    function automatic logic [29:0] exp_tab(input logic [4:0] k);
        logic [29:0] t;
        unique case (k)
            5'd0:  t = 30'd1073725440;
            5'd1:  t = 30'd1073709056;
            5'd2:  t = 30'd1073676290;
            5'd3:  t = 30'd1073610760;
            5'd4:  t = 30'd1073479712;
            5'd5:  t = 30'd1073217664;
            5'd6:  t = 30'd1072693760;
            5'd7:  t = 30'd1071646719;
            5'd8:  t = 30'd1069555701;
            5'd9:  t = 30'd1065385899;
            5'd10: t = 30'd1057095000;
            5'd11: t = 30'd1040706261;
            5'd12: t = 30'd1008687096;
            5'd13: t = 30'd947573834;
            5'd14: t = 30'd836230973;
            5'd15: t = 30'd651257337;
            5'd16: t = 30'd395007541;
            5'd17: t = 30'd145315154;
            5'd18: t = 30'd19666268;
            5'd19: t = 30'd360200;
            default: t = 30'd0;
        endcase
        return t;
    endfunction

endpackage

@@ src/eschcv_ctrl.sv @@
// ----------------------------------------------------------------------------
// eschcv_ctrl
// Sequencer for one sample: multiplies, divide, decay, voltage and output.
// ----------------------------------------------------------------------------
module eschcv_ctrl
    import eschcv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL0  = 4'd1;
    localparam logic [3:0] ST_MUL1  = 4'd2;
    localparam logic [3:0] ST_MUL2  = 4'd3;
    localparam logic [3:0] ST_XLOAD = 4'd4;
    localparam logic [3:0] ST_XDIV  = 4'd5;
    localparam logic [3:0] ST_EXP   = 4'd6;
    localparam logic [3:0] ST_HCALC = 4'd7;
    localparam logic [3:0] ST_VMUL  = 4'd8;
    localparam logic [3:0] ST_VCALC = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    localparam logic [5:0] X_LAST = 6'(X_STEPS - 1);
    localparam logic [5:0] E_LAST = 6'(EXP_TERMS - 1);
    localparam logic [5:0] V_LAST = 6'(V_TERMS - 1);

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                cmd.mul0   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_XLOAD;
            end
            ST_XLOAD:
            begin
                cmd.x_load = 1'b1;
                cnt_next   = X_LAST;
                state_next = ST_XDIV;
            end
            ST_XDIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = ST_EXP;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ST_EXP:
            begin
                cmd.exp_step = 1'b1;
                cmd.exp_idx  = cnt_reg[4:0];
                if (cnt_reg == E_LAST)
                begin
                    state_next = ST_HCALC;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_HCALC:
            begin
                cmd.h_calc = 1'b1;
                cnt_next   = 6'd0;
                state_next = ST_VMUL;
            end
            ST_VMUL:
            begin
                cmd.v_mul = 1'b1;
                cmd.v_idx = cnt_reg[1:0];
                if (cnt_reg == V_LAST)
                begin
                    state_next = ST_VCALC;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_VCALC:
            begin
                cmd.v_calc = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ src/eschcv_dp.sv @@
// ----------------------------------------------------------------------------
// eschcv_dp
// Datapath: config registers, multipliers, serial divider, decay, saturation.
// ----------------------------------------------------------------------------
module eschcv_dp
    import eschcv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic signed [23:0] current_ma,
    input  logic [22:0]        open_circuit_uv,
    input  logic signed [23:0] branch_current_ma,
    output logic signed [24:0] terminal_uv,
    output logic signed [15:0] hyst_state,
    output logic signed [1:0]  current_sign
);

    // configuration
    logic [16:0] eta_reg;
    logic [15:0] gamma_reg;
    logic [15:0] dt_reg;
    logic [19:0] cap_reg;
    logic [19:0] r0_reg;
    logic [19:0] r1_reg;
    logic [19:0] m0_reg;
    logic [19:0] m_reg;

    // model state
    logic signed [15:0] hyst_level_reg;
    logic signed [1:0]  last_sign_reg;

    // sample
    logic signed [23:0] cur_reg;
    logic [22:0]        ocv_reg;
    logic signed [23:0] ib_reg;
    logic signed [1:0]  sg_reg;
    logic signed [1:0]  s_reg;

    // work registers
    logic [40:0]        a_reg;
    logic [31:0]        b_reg;
    logic [49:0]        den_reg;
    logic signed [46:0] drop_reg;
    logic [63:0]        nlo_reg;
    logic [72:0]        num_reg;
    logic [72:0]        rem_reg;
    logic [72:0]        dvs_reg;
    logic [20:0]        q_reg;
    logic [30:0]        e_reg;
    logic signed [15:0] hnew_reg;
    logic               vneg_reg;
    logic [43:0]        vmag_reg;
    logic [88:0]        vacc_reg;
    logic signed [24:0] v_reg;

    // output beat
    logic signed [24:0] terminal_uv_reg;
    logic signed [15:0] hyst_state_reg;
    logic signed [1:0]  current_sign_reg;

    // combinational helpers
    logic [23:0]        mag;
    logic [19:0]        cap_eff;
    logic signed [1:0]  sg_in;
    logic [40:0]        hi_prod;
    logic               div_ge;
    logic [19:0]        xq;
    logic [60:0]        e_prod;
    logic [60:0]        e_rnd;
    logic [30:0]        e_eff;
    logic [30:0]        e_comp;
    logic signed [47:0] eh;
    logic signed [48:0] comp_s;
    logic signed [48:0] acc;
    logic signed [48:0] acc_r;
    logic signed [18:0] hq;
    logic signed [15:0] h_sat;
    logic signed [47:0] vn;
    logic [43:0]        vmag;
    logic [21:0]        v_opa;
    logic [22:0]        v_opb;
    logic [44:0]        v_prod;
    logic [88:0]        v_term;
    logic signed [35:0] qd;
    logic signed [36:0] mh_prod;
    logic signed [36:0] mh_sum;
    logic signed [21:0] mh_r;
    logic signed [39:0] m0s;
    logic signed [39:0] v_sum;
    logic signed [24:0] v_sat;

    always_comb
    begin
        mag     = cur_reg[23] ? 24'(-cur_reg) : 24'(cur_reg);
        cap_eff = (cap_reg == 20'd0) ? 20'd1 : cap_reg;
        if (current_ma > 24'sd0)
        begin
            sg_in = 2'sb01;
        end
        else if (current_ma < 24'sd0)
        begin
            sg_in = 2'sb11;
        end
        else
        begin
            sg_in = 2'sb00;
        end
        hi_prod = a_reg[40:32] * b_reg;
        div_ge  = (rem_reg >= dvs_reg);
        xq      = q_reg[19:0];
        e_prod  = e_reg * exp_tab(cmd.exp_idx);
        e_rnd   = e_prod + EXP_HALF;
    end

    // new hysteresis level; an overflowing exponent means full decay
    always_comb
    begin
        e_eff  = q_reg[X_STEPS - 1] ? 31'd0 : e_reg;
        e_comp = EXP_ONE - e_eff;
        eh     = $signed({1'b0, e_eff}) * hyst_level_reg;
        comp_s = $signed({3'b000, e_comp, 15'd0});
        unique case (sg_reg)
            2'sb01:  acc = 49'(eh) - comp_s;
            2'sb11:  acc = 49'(eh) + comp_s;
            default: acc = 49'(eh);
        endcase
        acc_r = acc + 49'sd536870912;
        hq    = $signed(acc_r[48:30]);
        if (hq > 19'sd32767)
        begin
            h_sat = 16'sh7FFF;
        end
        else if (hq < -19'sd32768)
        begin
            h_sat = 16'sh8000;
        end
        else
        begin
            h_sat = hq[15:0];
        end
        // floor((drop + 500) / 1000) taken on a magnitude
        vn   = 48'(drop_reg) + 48'sd500;
        vmag = vn[47] ? 44'(48'(-vn) + 48'd999) : 44'(vn);
    end

    // one partial product of magnitude times the reciprocal of 1000
    always_comb
    begin
        v_opa  = cmd.v_idx[0] ? vmag_reg[43:22] : vmag_reg[21:0];
        v_opb  = cmd.v_idx[1] ? V_RECIP_HI : {1'b0, V_RECIP_LO};
        v_prod = v_opa * v_opb;
        unique case (cmd.v_idx)
            2'd0:    v_term = 89'(v_prod);
            2'd3:    v_term = 89'(v_prod) << 44;
            default: v_term = 89'(v_prod) << 22;
        endcase
    end

    always_comb
    begin
        qd      = vneg_reg ? -$signed({1'b0, vacc_reg[88:54]})
                           : $signed({1'b0, vacc_reg[88:54]});
        mh_prod = $signed({1'b0, m_reg}) * hyst_level_reg;
        mh_sum  = mh_prod + 37'sd16384;
        mh_r    = $signed(mh_sum[36:15]);
        unique case (s_reg)
            2'sb01:  m0s = 40'($signed({1'b0, m0_reg}));
            2'sb11:  m0s = -40'($signed({1'b0, m0_reg}));
            default: m0s = 40'sd0;
        endcase
        v_sum = 40'($signed({1'b0, ocv_reg})) - 40'(qd) + 40'(mh_r) + m0s;
        if (v_sum > 40'sd16777215)
        begin
            v_sat = 25'sh0FF_FFFF;
        end
        else if (v_sum < -40'sd16777216)
        begin
            v_sat = 25'sh100_0000;
        end
        else
        begin
            v_sat = v_sum[24:0];
        end
    end

    // configuration and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg        <= 17'd65536;
            gamma_reg      <= 16'd256;
            dt_reg         <= 16'd1000;
            cap_reg        <= 20'd2000;
            r0_reg         <= '0;
            r1_reg         <= '0;
            m0_reg         <= '0;
            m_reg          <= '0;
            hyst_level_reg <= '0;
            last_sign_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EFFICIENCY: eta_reg   <= cfg_data[16:0];
                    CFG_RATE:       gamma_reg <= cfg_data[15:0];
                    CFG_STEP_MS:    dt_reg    <= cfg_data[15:0];
                    CFG_CAPACITY:   cap_reg   <= cfg_data;
                    CFG_R0:         r0_reg    <= cfg_data;
                    CFG_R1:         r1_reg    <= cfg_data;
                    CFG_M0:         m0_reg    <= cfg_data;
                    CFG_M:          m_reg     <= cfg_data;
                    default:        m_reg     <= m_reg;
                endcase
            end
            if (cmd.out_load)
            begin
                hyst_level_reg <= hnew_reg;
                last_sign_reg  <= s_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_reg <= current_ma;
            ocv_reg <= open_circuit_uv;
            ib_reg  <= branch_current_ma;
            sg_reg  <= sg_in;
            s_reg   <= (sg_in != 2'sb00) ? sg_in : last_sign_reg;
        end
        if (cmd.mul0)
        begin
            a_reg    <= mag * eta_reg;
            b_reg    <= gamma_reg * dt_reg;
            den_reg  <= DEN_SCALE * cap_eff;
            drop_reg <= $signed({1'b0, r1_reg}) * ib_reg;
        end
        if (cmd.mul1)
        begin
            nlo_reg  <= a_reg[31:0] * b_reg;
            drop_reg <= drop_reg + $signed({1'b0, r0_reg}) * cur_reg;
        end
        if (cmd.mul2)
        begin
            num_reg <= {9'd0, nlo_reg} + {hi_prod, 32'd0};
        end
        if (cmd.x_load)
        begin
            rem_reg <= num_reg;
            dvs_reg <= {3'd0, den_reg, 20'd0};
            q_reg   <= '0;
            e_reg   <= EXP_ONE;
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            q_reg   <= {q_reg[19:0], div_ge};
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.exp_step && xq[cmd.exp_idx])
        begin
            e_reg <= e_rnd[60:30];
        end
        if (cmd.h_calc)
        begin
            hnew_reg <= h_sat;
            vneg_reg <= vn[47];
            vmag_reg <= vmag;
            vacc_reg <= '0;
        end
        if (cmd.v_mul)
        begin
            vacc_reg <= vacc_reg + v_term;
        end
        if (cmd.v_calc)
        begin
            v_reg <= v_sat;
        end
        if (cmd.out_load)
        begin
            terminal_uv_reg  <= v_reg;
            hyst_state_reg   <= hnew_reg;
            current_sign_reg <= s_reg;
        end
    end

    assign terminal_uv  = terminal_uv_reg;
    assign hyst_state   = hyst_state_reg;
    assign current_sign = current_sign_reg;

endmodule

@@ src/esc_hysteresis_cell_voltage_unit.sv @@
// ----------------------------------------------------------------------------
// esc_hysteresis_cell_voltage_unit
// One time step of the self-correcting cell model with hysteresis.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------------
//  in      | in_valid / in_stall      | current_ma, open_circuit_uv,
//          |                          | branch_current_ma
//  out     | out_valid / out_stall    | terminal_uv, hyst_state, current_sign
//  cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  The unit takes a new sample only once the last one has been loaded
//  into the output register. Each sample runs through the multiply steps,
//  21 restoring divide steps for the decay exponent, 20 serial decay
//  products, 4 reciprocal partial products for the microvolt scaling, and
//  the hysteresis, voltage and output steps.
//  A stalled result holds in the output register while the next sample is
//  computed; that sample waits in its last step until the register frees.
//  Reset restores the register defaults and clears hysteresis and sign.
//
//  Terminal voltage uses the hysteresis level held before the sample; the
//  level and the held sign then advance to the values the result reports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esc_hysteresis_cell_voltage_unit
    import eschcv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input samples
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] current_ma,
    input  logic [22:0]        open_circuit_uv,
    input  logic signed [23:0] branch_current_ma,
    // results
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [24:0] terminal_uv,
    output logic signed [15:0] hyst_state,
    output logic signed [1:0]  current_sign,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data
);

    dp_cmd_t cmd;

    // Take configuration beats at any time; the sender must issue them only while idle, the unit does not enforce it.
    assign cfg_ready = 1'b1;

    eschcv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    eschcv_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .current_ma        (current_ma),
        .open_circuit_uv   (open_circuit_uv),
        .branch_current_ma (branch_current_ma),
        .terminal_uv       (terminal_uv),
        .hyst_state        (hyst_state),
        .current_sign      (current_sign)
    );

    // Hold off further samples once one is taken.
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
    // Report a sign of -1, 0 or +1 only.
    `ASSERT_HOLDS(a_sign_code, clk, rst_n, out_valid, current_sign != 2'b10)
    // A fresh result leaves the sequencer ready for the next sample.
    `ASSERT_HOLDS(a_free_on_result, clk, rst_n, $rose(out_valid), !in_stall)

endmodule

@@ bench/esc_hysteresis_cell_voltage_checker.sv @@
// ----------------------------------------------------------------------------
// esc_hysteresis_cell_voltage_checker
// Watches the sample, result and register channels of the cell voltage unit.
// It predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module esc_hysteresis_cell_voltage_checker
    import eschcv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [23:0] current_ma,
    input  logic [22:0]        open_circuit_uv,
    input  logic signed [23:0] branch_current_ma,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [24:0] terminal_uv,
    input  logic signed [15:0] hyst_state,
    input  logic signed [1:0]  current_sign,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic signed [24:0] volt;
        logic signed [15:0] level;
        logic signed [1:0]  sign;
    } cell_result_t;

    localparam logic [31:0] DECAY_TAB [20] = '{
        32'd1073725440, 32'd1073709056, 32'd1073676290, 32'd1073610760,
        32'd1073479712, 32'd1073217664, 32'd1072693760, 32'd1071646719,
        32'd1069555701, 32'd1065385899, 32'd1057095000, 32'd1040706261,
        32'd1008687096, 32'd947573834,  32'd836230973,  32'd651257337,
        32'd395007541,  32'd145315154,  32'd19666268,   32'd360200
    };

    cell_result_t       cell_results_q[$];
    logic [16:0]        eff;
    logic [15:0]        gamma_q88;
    logic [15:0]        dt_ms;
    logic [19:0]        cap_mah;
    logic [19:0]        r0_uohm;
    logic [19:0]        r1_uohm;
    logic [19:0]        m0_uv;
    logic [19:0]        m_uv;
    logic signed [15:0] level;
    logic signed [1:0]  held_sign;

    assign pending = cell_results_q.size();

    function automatic longint floor_by(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // Decay factor in Q30 for a current magnitude.
    function automatic longint unsigned decay_q30(input longint unsigned mag);
        logic [127:0]    num;
        logic [127:0]    den;
        logic [127:0]    x;
        longint unsigned e;
        num = 128'(mag) * 128'(eff) * 128'(gamma_q88) * 128'(dt_ms);
        den = 128'(921600000) * 128'((cap_mah == 0) ? 20'd1 : cap_mah);
        x = num / den;
        if (x >= 128'(1 << 20))
            return 0;
        e = 64'd1 << 30;
        for (int k = 0; k < 20; k++)
            if (x[k])
                e = (e * DECAY_TAB[k] + (64'd1 << 29)) >> 30;
        return e;
    endfunction

    function automatic cell_result_t advance_cell(input longint i, input longint ocv,
                                                  input longint ib);
        cell_result_t    r;
        longint          sg;
        longint          s;
        longint          v;
        longint          acc;
        longint          h;
        longint unsigned e;
        sg = (i > 0) ? 1 : ((i < 0) ? -1 : 0);
        s = (sg != 0) ? sg : longint'(held_sign);
        v = ocv - floor_by(longint'(r1_uohm) * ib + longint'(r0_uohm) * i + 500, 1000)
            + floor_by(longint'(m_uv) * longint'(level) + 16384, 32768)
            + longint'(m0_uv) * s;
        if (v > 16777215)
            v = 16777215;
        if (v < -16777216)
            v = -16777216;
        e = decay_q30((i < 0) ? -i : i);
        acc = longint'(e) * longint'(level) - (longint'(1 << 30) - longint'(e)) * sg * 32768;
        h = floor_by(acc + (1 << 29), 1 << 30);
        if (h > 32767)
            h = 32767;
        if (h < -32768)
            h = -32768;
        level = 16'(h);
        held_sign = 2'(s);
        r.volt = 25'(v);
        r.level = 16'(h);
        r.sign = 2'(s);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t exp_r;
        if (!rst_n)
        begin
            eff = 17'd65536;
            gamma_q88 = 16'd256;
            dt_ms = 16'd1000;
            cap_mah = 20'd2000;
            r0_uohm = '0;
            r1_uohm = '0;
            m0_uv = '0;
            m_uv = '0;
            level = '0;
            held_sign = '0;
            fail_count = 0;
            cell_results_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EFFICIENCY: eff = cfg_data[16:0];
                    CFG_RATE:       gamma_q88 = cfg_data[15:0];
                    CFG_STEP_MS:    dt_ms = cfg_data[15:0];
                    CFG_CAPACITY:   cap_mah = cfg_data;
                    CFG_R0:         r0_uohm = cfg_data;
                    CFG_R1:         r1_uohm = cfg_data;
                    CFG_M0:         m0_uv = cfg_data;
                    CFG_M:          m_uv = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (cell_results_q.size() == 0)
                begin
                    $error("result beat with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_r = cell_results_q.pop_front();
                    if (terminal_uv !== exp_r.volt)
                    begin
                        $error("terminal_uv expected %0d actual %0d", exp_r.volt, terminal_uv);
                        fail_count++;
                    end
                    if (hyst_state !== exp_r.level)
                    begin
                        $error("hyst_state expected %0d actual %0d", exp_r.level, hyst_state);
                        fail_count++;
                    end
                    if (current_sign !== exp_r.sign)
                    begin
                        $error("current_sign expected %0d actual %0d", exp_r.sign,
                               current_sign);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                cell_results_q.push_back(advance_cell(longint'(current_ma),
                                                      longint'(open_circuit_uv),
                                                      longint'(branch_current_ma)));
        end
    end

endmodule

@@ bench/tb_esc_hysteresis_cell_voltage_unit.sv @@
// ----------------------------------------------------------------------------
// tb_esc_hysteresis_cell_voltage_unit
// Drives directed and random samples and register settings into the cell
// voltage unit under varying idle and stall patterns; a side checker
// predicts each result and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_esc_hysteresis_cell_voltage_unit
    import eschcv_pkg::*;
;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] current_ma;
    logic [22:0]        open_circuit_uv;
    logic signed [23:0] branch_current_ma;
    logic               out_valid;
    logic               out_stall;
    logic signed [24:0] terminal_uv;
    logic signed [15:0] hyst_state;
    logic signed [1:0]  current_sign;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [19:0]        cfg_data;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    esc_hysteresis_cell_voltage_unit u_top (.*);

    esc_hysteresis_cell_voltage_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #30_000_000;
        $display("[esc_hysteresis_cell_voltage_unit] ERROR");
        $finish;
    end

    // Receiver stall: redraw every cycle at the current rate.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Write one register and hold the beat until the unit takes it.
    task automatic reg_write(input logic [2:0] idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_cell(input logic [19:0] e, input logic [19:0] g,
                                input logic [19:0] dt, input logic [19:0] cap,
                                input logic [19:0] r0, input logic [19:0] r1,
                                input logic [19:0] m0, input logic [19:0] m);
        reg_write(CFG_EFFICIENCY, e);
        reg_write(CFG_RATE, g);
        reg_write(CFG_STEP_MS, dt);
        reg_write(CFG_CAPACITY, cap);
        reg_write(CFG_R0, r0);
        reg_write(CFG_R1, r1);
        reg_write(CFG_M0, m0);
        reg_write(CFG_M, m);
    endtask

    // Hold until every predicted result has come back.
    task automatic drain();
        while (pending != 0)
            @(posedge clk);
    endtask

    // Present one sample, hold it until accepted, then maybe idle.
    task automatic send_sample(input logic signed [23:0] i, input logic [22:0] ocv,
                               input logic signed [23:0] ib);
        in_valid <= 1'b1;
        current_ma <= i;
        open_circuit_uv <= ocv;
        branch_current_ma <= ib;
        do @(posedge clk); while (in_stall);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    function automatic logic signed [23:0] pick_current();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(2000)) - 1000);
            2: return '0;
            default: return 24'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    task automatic random_config();
        program_cell(20'($urandom_range(131071)), 20'($urandom_range(65535)),
                     20'($urandom_range(1, 65535)), 20'($urandom_range(1, 1000000)),
                     20'($urandom_range(1000000)), 20'($urandom_range(1000000)),
                     20'($urandom_range(1000000)), 20'($urandom_range(1000000)));
    endtask

    task automatic random_run(input int count);
        for (int n = 0; n < count; n++)
        begin
            // hold off once mid-run until the pipeline is empty
            if (n == count / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                drain();
            end
            // switch registers now and then, only when idle
            if (n % 200 == 199)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                drain();
                random_config();
            end
            send_sample(pick_current(), 23'($urandom_range(8000000)),
                        ($urandom_range(1)) ? 24'($urandom)
                                            : 24'($signed($urandom_range(2000)) - 1000));
        end
        in_valid <= 1'b0;
        @(posedge clk);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        current_ma = '0;
        open_circuit_uv = '0;
        branch_current_ma = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 12;
        recv_stall_pct = 67;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults first: zero current holds the sign, a small current moves h slowly.
        send_sample(24'sd0, 23'd3700000, 24'sd0);
        send_sample(24'sd1000, 23'd3700000, -24'sd1);
        send_sample(24'sd0, 23'd3700000, 24'sd0);
        send_sample(-24'sd8388608, 23'd0, 24'sd8388607);
        in_valid <= 1'b0;
        @(posedge clk);
        drain();

        // Tiny capacity and full gains: drive h to both rails, saturate voltage.
        program_cell(20'd65536, 20'd256, 20'd1000, 20'd1, 20'd1000000, 20'd1000000,
                     20'd1000000, 20'd1000000);
        send_sample(-24'sd8388608, 23'd8000000, -24'sd8388608);
        send_sample(-24'sd1, 23'd8000000, -24'sd8388608);
        send_sample(24'sd0, 23'd8000000, -24'sd8388608);
        send_sample(24'sd8388607, 23'd0, 24'sd8388607);
        send_sample(24'sd1, 23'd0, 24'sd8388607);
        send_sample(24'sd0, 23'd0, 24'sd0);
        send_sample(-24'sd8388608, 23'd8000000, 24'sd0);
        in_valid <= 1'b0;
        @(posedge clk);
        drain();

        // Zero capacity, efficiency above one, zero rate and zero efficiency.
        program_cell(20'h1FFFF, 20'd65535, 20'd65535, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
        send_sample(24'sd1, 23'd1, 24'sd1);
        send_sample(-24'sd3, 23'd4194304, 24'sd0);
        in_valid <= 1'b0;
        @(posedge clk);
        drain();
        reg_write(CFG_RATE, 20'd0);
        send_sample(24'sd8388607, 23'd5, 24'sd0);
        in_valid <= 1'b0;
        @(posedge clk);
        drain();
        reg_write(CFG_EFFICIENCY, 20'd0);
        send_sample(-24'sd8388608, 23'd5, 24'sd0);
        in_valid <= 1'b0;
        @(posedge clk);
        drain();

        // Random phases: sender idles lightly, then heavily, then never.
        program_cell(20'd65536, 20'd256, 20'd1000, 20'd2000, 20'd5000, 20'd3000,
                     20'd20000, 20'd50000);
        random_run(670);
        send_idle_pct = 67;
        recv_stall_pct = 12;
        program_cell(20'd60000, 20'd2560, 20'd65535, 20'd1, 20'd1000000, 20'd1000000,
                     20'd1000000, 20'd1000000);
        random_run(670);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_config();
        random_run(670);

        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("[esc_hysteresis_cell_voltage_unit] OK");
        else
            $display("[esc_hysteresis_cell_voltage_unit] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/eschcv_pkg.sv
src/eschcv_ctrl.sv
src/eschcv_dp.sv
src/esc_hysteresis_cell_voltage_unit.sv
bench/esc_hysteresis_cell_voltage_checker.sv
bench/tb_esc_hysteresis_cell_voltage_unit.sv
